### hdl/mva_pkg.sv
// types, codes and the pitch table for the midi voice allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

   localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

   localparam logic EV_START = 1'b0;
   localparam logic EV_MUTE  = 1'b1;

   localparam int          TABLE_LEN  = 116;
   localparam logic [6:0]  TABLE_LAST = 7'(TABLE_LEN - 1);

   typedef struct packed {
      logic [3:0] cmd;
      logic [6:0] note;
   } req_type;

   typedef struct packed {
      logic [2:0]  voice;
      logic        event_kind;
      logic [12:0] tone_hz;
   } rsp_type;

   // write command from the sequencer into the voice store
   typedef struct packed {
      logic en;
      logic busy;
   } store_wr_type;

   localparam logic [12:0] PITCH_HZ [0:TABLE_LEN-1] = '{
      13'd8,    13'd9,    13'd9,    13'd10,   13'd10,   13'd11,
      13'd12,   13'd12,   13'd13,   13'd14,   13'd15,   13'd15,
      13'd16,   13'd17,   13'd18,   13'd19,   13'd21,   13'd22,
      13'd23,   13'd25,   13'd26,   13'd28,   13'd29,   13'd31,
      13'd33,   13'd35,   13'd37,   13'd39,   13'd41,   13'd44,
      13'd46,   13'd49,   13'd52,   13'd55,   13'd58,   13'd62,
      13'd65,   13'd69,   13'd73,   13'd78,   13'd82,   13'd87,
      13'd93,   13'd98,   13'd104,  13'd110,  13'd117,  13'd123,
      13'd131,  13'd139,  13'd147,  13'd156,  13'd165,  13'd175,
      13'd185,  13'd196,  13'd208,  13'd220,  13'd233,  13'd247,
      13'd262,  13'd277,  13'd294,  13'd311,  13'd330,  13'd349,
      13'd370,  13'd392,  13'd415,  13'd440,  13'd466,  13'd494,
      13'd523,  13'd554,  13'd587,  13'd622,  13'd659,  13'd698,
      13'd740,  13'd784,  13'd831,  13'd880,  13'd932,  13'd988,
      13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397,
      13'd1480, 13'd1568, 13'd1661, 13'd1760, 13'd1865, 13'd1976,
      13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794,
      13'd2960, 13'd3136, 13'd3322, 13'd3520, 13'd3729, 13'd3951,
      13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
      13'd5920, 13'd6272
   };

   // notes above the table saturate to its last entry
   function automatic logic [12:0] pitch_of(input logic [6:0] note);
      logic [6:0] n;
      n = (note > TABLE_LAST) ? TABLE_LAST : note;
      return PITCH_HZ[n];
   endfunction

endpackage

`default_nettype wire

### hdl/mva_voice_store.sv
// per-voice busy flags and held note numbers
// depends on mva_pkg
`timescale 1ns / 1ps
`default_nettype none

module mva_voice_store #(
   parameter int VOICES = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] rd_idx,
   output logic                                rd_busy,
   output logic [6:0]                          rd_note,
   input  mva_pkg::store_wr_type               wr_cmd,
   input  wire  [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] wr_idx,
   input  wire  [6:0]                          wr_note
);
   import mva_pkg::*;

   logic [VOICES-1:0] busy_ff;
   logic [VOICES-1:0] busy_in;
   logic [6:0]        note_ff [0:VOICES-1];

   always_comb begin
      busy_in = busy_ff;
      if (wr_cmd.en) begin
         busy_in[wr_idx] = wr_cmd.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // note entries only matter while the voice is busy
   always_ff @(posedge clock) begin
      if (wr_cmd.en && wr_cmd.busy) begin
         note_ff[wr_idx] <= wr_note;
      end
   end

   assign rd_busy = busy_ff[rd_idx];
   assign rd_note = note_ff[rd_idx];

endmodule

`default_nettype wire

### hdl/mva_scan_seq.sv
// voice scan sequencer: one shared voice compare stepped over the voices
// depends on mva_pkg; drives mva_voice_store
`timescale 1ns / 1ps
`default_nettype none

module mva_scan_seq #(
   parameter int VOICES = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  mva_pkg::req_type                    req_data,
   output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] st_idx,
   input  wire                                 st_busy,
   input  wire  [6:0]                          st_note,
   output mva_pkg::store_wr_type               st_wr,
   output logic [6:0]                          st_wr_note,
   output logic                                res_valid,
   input  wire                                 res_take,
   output logic                                res_kind,
   output logic [6:0]                          res_note
);
   import mva_pkg::*;

   localparam int               IDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             on_ff, on_in;
   logic [6:0]       note_ff, note_in;
   logic             hit;

   assign req_ready = (state_ff == ST_IDLE);

   // note-on wants a free voice, note-off a busy voice holding the note
   assign hit = on_ff ? !st_busy : (st_busy && (st_note == note_ff));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      on_in    = on_ff;
      note_in  = note_ff;
      st_wr    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in  = '0;
               on_in   = (req_data.cmd == CMD_NOTE_ON);
               note_in = req_data.note;
               if (req_data.cmd == CMD_NOTE_ON || req_data.cmd == CMD_NOTE_OFF) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               st_wr.en   = 1'b1;
               st_wr.busy = on_ff;
               state_in   = ST_HOLD;
            end else if (idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      on_ff   <= on_in;
      note_ff <= note_in;
   end

   assign st_idx     = idx_ff;
   assign st_wr_note = note_ff;
   assign res_valid  = (state_ff == ST_HOLD);
   assign res_kind   = on_ff ? EV_START : EV_MUTE;
   assign res_note   = note_ff;

endmodule

`default_nettype wire

### hdl/midi_voice_allocator_top.sv
// top level of the midi voice allocator: sequencer, voice store, response register
// depends on mva_pkg, mva_voice_store, mva_scan_seq
`timescale 1ns / 1ps
`default_nettype none

// Takes note-on and note-off requests and assigns them to VOICES voices,
// lowest free voice first. A note-on that finds a free voice returns that
// voice with the note's pitch in hertz; a note-off returns a mute for the
// lowest busy voice holding the note. Other commands, unmatched note-offs
// and note-ons with every voice busy return nothing. One request is handled
// at a time: the sequencer checks one voice per cycle through a single
// compare. Other commands are dropped on acceptance; otherwise a request
// occupies the block while it scans up to the matching voice and hands the
// response off, or until the scan passes the last voice without a match.
// The handoff waits while the response register still holds an unaccepted
// response and rsp_ready is low. The response register lets the next request
// in while a response still waits for rsp_ready.
module midi_voice_allocator_top #(
   parameter int VOICES = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  mva_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output mva_pkg::rsp_type  rsp_data
);
   import mva_pkg::*;

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   logic [IDX_W-1:0] st_idx;
   logic             st_busy;
   logic [6:0]       st_note;
   store_wr_type     st_wr;
   logic [6:0]       st_wr_note;
   logic             res_valid;
   logic             res_take;
   logic             res_kind;
   logic [6:0]       res_note;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   mva_scan_seq #(
      .VOICES (VOICES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .st_idx     (st_idx),
      .st_busy    (st_busy),
      .st_note    (st_note),
      .st_wr      (st_wr),
      .st_wr_note (st_wr_note),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res_kind   (res_kind),
      .res_note   (res_note)
   );

   mva_voice_store #(
      .VOICES (VOICES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (st_idx),
      .rd_busy (st_busy),
      .rd_note (st_note),
      .wr_cmd  (st_wr),
      .wr_idx  (st_idx),
      .wr_note (st_wr_note)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.voice      = 3'(st_idx);
         rsp_data_in.event_kind = res_kind;
         rsp_data_in.tone_hz    = (res_kind == EV_START) ? pitch_of(res_note) : 13'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
